// ===== src/ldla_pkg.sv =====
// Shared constants, types and helpers for the diffuse light accumulator.
// Depends on nothing; imported by ldla_unit and the top level.
`default_nettype none

package ldla_pkg;

	localparam int GRID_POINTS = 256;
	localparam int ADDR_W      = $clog2(GRID_POINTS);
	localparam int SQRT_STEPS  = 16;
	localparam int DIV_STEPS   = 17;

	// configuration register indexes
	localparam logic [2:0] REG_KIND    = 3'd0;
	localparam logic [2:0] REG_LIGHT_X = 3'd1;
	localparam logic [2:0] REG_LIGHT_Y = 3'd2;
	localparam logic [2:0] REG_LIGHT_Z = 3'd3;
	localparam logic [2:0] REG_AXIS_X  = 3'd4;
	localparam logic [2:0] REG_AXIS_Y  = 3'd5;
	localparam logic [2:0] REG_AXIS_Z  = 3'd6;
	localparam logic [2:0] REG_CONE    = 3'd7;

	// light kinds
	localparam logic [2:0] KIND_SOLAR      = 3'd0;
	localparam logic [2:0] KIND_SOLAR_CONE = 3'd1;
	localparam logic [2:0] KIND_POINT      = 3'd2;
	localparam logic [2:0] KIND_POINT_CONE = 3'd3;
	localparam logic [2:0] KIND_NONE       = 3'd4;

	typedef struct packed {
		logic [7:0]        idx;
		logic              first;
		logic [2:0][31:0]  nrm;
		logic [2:0][15:0]  col;
	} pay_t;

	function automatic logic [5:0] msb_pos(input logic [32:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 33; i++) begin
			if (v[i]) p = 6'(i);
		end
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== src/ldla_unit.sv =====
// Pipelined unit vector: block scaling, digit-by-digit square root, and
// three restoring dividers. Depends on ldla_pkg.
`default_nettype none

module ldla_unit import ldla_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_vld,
	input  logic [2:0][32:0]  lvec,
	input  pay_t              in_pay,
	output logic              out_vld,
	output logic [2:0][17:0]  u,
	output pay_t              out_pay
);

	typedef struct packed {
		pay_t             pay;
		logic [2:0][14:0] r;
		logic [2:0]       neg;
		logic             zero;
	} carry_t;

	// stage 1: magnitudes and largest magnitude
	logic [2:0][32:0] mag_in;
	logic [2:0]       neg_in;
	logic [32:0]      m_in;

	always_comb begin
		m_in = '0;
		for (int i = 0; i < 3; i++) begin
			neg_in[i] = lvec[i][32];
			mag_in[i] = neg_in[i] ? 33'(-lvec[i]) : lvec[i];
			if (mag_in[i] > m_in) m_in = mag_in[i];
		end
	end

	logic             v_s1;
	pay_t             pay_s1;
	logic [2:0][32:0] mag_s1;
	logic [2:0]       neg_s1;
	logic [32:0]      m_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_s1 <= in_pay;
			mag_s1 <= mag_in;
			neg_s1 <= neg_in;
			m_s1   <= m_in;
		end
	end

	// stage 2: normalising shift
	logic [5:0] p_s1;
	assign p_s1 = msb_pos(m_s1);

	logic             v_s2;
	pay_t             pay_s2;
	logic [2:0][32:0] mag_s2;
	logic [2:0]       neg_s2;
	logic             zero_s2;
	logic             shl_s2;
	logic [5:0]       amt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_s2  <= pay_s1;
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			zero_s2 <= (m_s1 == '0);
			shl_s2  <= (p_s1 < 6'd15);
			amt_s2  <= (p_s1 < 6'd15) ? 6'd14 - p_s1 : p_s1 - 6'd14;
		end
	end

	// stage 3: scaled magnitudes in [0, 2^15)
	logic [2:0][32:0] shf;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			shf[i] = shl_s2 ? (mag_s2[i] << amt_s2) : (mag_s2[i] >> amt_s2);
		end
	end

	logic   v_s3;
	carry_t c_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s3.pay  <= pay_s2;
			c_s3.neg  <= neg_s2;
			c_s3.zero <= zero_s2;
			for (int i = 0; i < 3; i++) c_s3.r[i] <= shf[i][14:0];
		end
	end

	// stage 4: squares
	logic             v_s4;
	carry_t           c_s4;
	logic [2:0][29:0] sq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s4 <= c_s3;
			for (int i = 0; i < 3; i++) sq_s4[i] <= c_s3.r[i] * c_s3.r[i];
		end
	end

	// stage 5 and on: sum of squares, then one root digit per stage
	logic        sqv_s [SQRT_STEPS+1];
	logic [31:0] sqx_s [SQRT_STEPS+1];
	logic [32:0] sqr_s [SQRT_STEPS+1];
	carry_t      sqc_s [SQRT_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sqv_s[0] <= 1'b0;
		else if (adv) sqv_s[0] <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s[0] <= 32'(sq_s4[0]) + 32'(sq_s4[1]) + 32'(sq_s4[2]);
			sqr_s[0] <= '0;
			sqc_s[0] <= c_s4;
		end
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [32:0] BIT = 33'd1 << (2 * (SQRT_STEPS - 1) - 2 * k);
		logic [32:0] t;
		logic        take;

		always_comb begin
			t    = sqr_s[k] + BIT;
			take = {1'b0, sqx_s[k]} >= t;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sqv_s[k+1] <= 1'b0;
			else if (adv) sqv_s[k+1] <= sqv_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sqx_s[k+1] <= take ? sqx_s[k] - t[31:0] : sqx_s[k];
				sqr_s[k+1] <= take ? (sqr_s[k] >> 1) + BIT : sqr_s[k] >> 1;
				sqc_s[k+1] <= sqc_s[k];
			end
		end
	end

	// restoring division, one quotient bit per stage and lane
	logic             dv_v_s   [DIV_STEPS];
	logic [2:0][16:0] dv_rem_s [DIV_STEPS];
	logic [2:0][16:0] dv_q_s   [DIV_STEPS];
	logic [15:0]      dv_len_s [DIV_STEPS];
	carry_t           dv_c_s   [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic             v_i;
		logic [2:0][16:0] rem_i;
		logic [2:0][16:0] q_i;
		logic [2:0]       nb_i;
		logic [15:0]      len_i;
		carry_t           c_i;
		logic [2:0][17:0] t;
		logic [2:0]       ge;

		if (k == 0) begin : g_head
			always_comb begin
				v_i   = sqv_s[SQRT_STEPS];
				c_i   = sqc_s[SQRT_STEPS];
				len_i = sqr_s[SQRT_STEPS][15:0];
				q_i   = '0;
				for (int i = 0; i < 3; i++) begin
					rem_i[i] = 17'(c_i.r[i][14:1]);
					nb_i[i]  = c_i.r[i][0];
				end
			end
		end else begin : g_body
			always_comb begin
				v_i   = dv_v_s[k-1];
				c_i   = dv_c_s[k-1];
				len_i = dv_len_s[k-1];
				q_i   = dv_q_s[k-1];
				rem_i = dv_rem_s[k-1];
				nb_i  = '0;
			end
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				t[i]  = {rem_i[i], nb_i[i]};
				ge[i] = t[i] >= {2'b00, len_i};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[k] <= 1'b0;
			else if (adv) dv_v_s[k] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_len_s[k] <= len_i;
				dv_c_s[k]   <= c_i;
				for (int i = 0; i < 3; i++) begin
					dv_rem_s[k][i] <= ge[i] ? 17'(t[i] - {2'b00, len_i}) : t[i][16:0];
					dv_q_s[k][i]   <= {q_i[i][15:0], ge[i]};
				end
			end
		end
	end

	// signed unit components; a zero-length vector gives zero
	carry_t c_out;
	assign c_out   = dv_c_s[DIV_STEPS-1];
	assign out_vld = dv_v_s[DIV_STEPS-1];
	assign out_pay = c_out.pay;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (c_out.zero) u[i] = '0;
			else if (c_out.neg[i]) u[i] = 18'(-{1'b0, dv_q_s[DIV_STEPS-1][i]});
			else u[i] = {1'b0, dv_q_s[DIV_STEPS-1][i]};
		end
	end

endmodule

`default_nettype wire

// ===== src/lambert_diffuse_light_accumulate.sv =====
// Top level: configuration registers, dot products, cone tests, Lambert term
// and the per-point accumulator memory. Depends on ldla_pkg and ldla_unit.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------
//  point   | point_valid / point_stall  | point_index, first_light, pos, normal, light colour
//  color   | color_valid / color_stall  | color_red, color_green, color_blue
//  cfg     | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One point per cycle unless color_stall holds the pipe. The unit vector pipe
// holds 16 square-root stages and 17 divider stages.
// The accumulator store is read one stage ahead of the add and written back
// as the result is registered; a write to the entry just read is forwarded.
// The whole pipe holds while a result waits under color_stall.
// Reset clears valids and configuration; the store needs no clearing.
`default_nettype none

module lambert_diffuse_light_accumulate import ldla_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               point_valid,
	output logic               point_stall,
	input  logic [7:0]         point_index,
	input  logic               first_light,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] normal_x,
	input  logic signed [31:0] normal_y,
	input  logic signed [31:0] normal_z,
	input  logic [15:0]        light_red,
	input  logic [15:0]        light_green,
	input  logic [15:0]        light_blue,
	output logic               color_valid,
	input  logic               color_stall,
	output logic [15:0]        color_red,
	output logic [15:0]        color_green,
	output logic [15:0]        color_blue
);

	// configuration
	logic [2:0]        kind_q;
	logic [2:0][31:0]  light_q;
	logic [2:0][31:0]  axis_q;
	logic [17:0]       cone_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_NONE;
			light_q <= '0;
			axis_q  <= '0;
			cone_q  <= 18'h10000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KIND:    kind_q     <= cfg_data[2:0];
				REG_LIGHT_X: light_q[0] <= cfg_data;
				REG_LIGHT_Y: light_q[1] <= cfg_data;
				REG_LIGHT_Z: light_q[2] <= cfg_data;
				REG_AXIS_X:  axis_q[0]  <= cfg_data;
				REG_AXIS_Y:  axis_q[1]  <= cfg_data;
				REG_AXIS_Z:  axis_q[2]  <= cfg_data;
				REG_CONE:    cone_q     <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	logic adv;
	assign adv         = !color_valid || !color_stall;
	assign point_stall = !adv;

	// light vector
	logic [2:0][31:0] pos;
	logic [2:0][32:0] lvec;
	logic             solar;
	pay_t             in_pay;

	assign pos   = {pos_z, pos_y, pos_x};
	assign solar = (kind_q == KIND_SOLAR) || (kind_q == KIND_SOLAR_CONE);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (solar) lvec[i] = 33'(-{light_q[i][31], light_q[i]});
			else lvec[i] = {light_q[i][31], light_q[i]} - {pos[i][31], pos[i]};
		end
		in_pay.idx   = point_index;
		in_pay.first = first_light;
		in_pay.nrm   = {normal_z, normal_y, normal_x};
		in_pay.col   = {light_blue, light_green, light_red};
	end

	logic             u_vld;
	logic [2:0][17:0] u;
	pay_t             u_pay;

	ldla_unit u_unit (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (point_valid && adv),
		.lvec    (lvec),
		.in_pay  (in_pay),
		.out_vld (u_vld),
		.u       (u),
		.out_pay (u_pay)
	);

	// stage 1: products
	logic signed [17:0] nu [3];
	logic signed [32:0] nn [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nu[i] = -$signed(u[i]);
			nn[i] = -$signed({u_pay.nrm[i][31], u_pay.nrm[i]});
		end
	end

	logic               v_s1;
	pay_t               pay_s1;
	logic signed [49:0] pd_s1 [3];
	logic signed [49:0] pe_s1 [3];
	logic signed [64:0] ps_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= u_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_s1 <= u_pay;
			for (int i = 0; i < 3; i++) begin
				pd_s1[i] <= $signed(u_pay.nrm[i]) * $signed(u[i]);
				pe_s1[i] <= $signed(axis_q[i]) * nu[i];
				ps_s1[i] <= $signed(axis_q[i]) * nn[i];
			end
		end
	end

	// stage 2: sums and tests
	logic signed [51:0] d_sum;
	logic signed [51:0] e_sum;
	logic signed [66:0] s_sum;
	logic signed [33:0] cosq;
	logic               pass;

	always_comb begin
		d_sum = 52'(pd_s1[0]) + 52'(pd_s1[1]) + 52'(pd_s1[2]);
		e_sum = 52'(pe_s1[0]) + 52'(pe_s1[1]) + 52'(pe_s1[2]);
		s_sum = 67'(ps_s1[0]) + 67'(ps_s1[1]) + 67'(ps_s1[2]);
		cosq  = $signed({cone_q, 16'h0000});
		case (kind_q)
			KIND_SOLAR, KIND_POINT: pass = !d_sum[51];
			KIND_SOLAR_CONE:        pass = !d_sum[51] && (s_sum >= 67'(cosq));
			KIND_POINT_CONE:        pass = !d_sum[51] && (e_sum >= 52'(cosq));
			default:                pass = 1'b0;
		endcase
	end

	logic        v_s2;
	pay_t        pay_s2;
	logic [35:0] dq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_s2 <= pay_s1;
			dq_s2  <= pass ? d_sum[51:16] : '0;
		end
	end

	// stage 3: colour terms, store read
	logic [2:0][51:0] cprod;

	always_comb begin
		for (int i = 0; i < 3; i++) cprod[i] = dq_s2 * pay_s2.col[i];
	end

	logic             v_s3;
	pay_t             pay_s3;
	logic [2:0][15:0] ct_s3;
	logic [2:0][15:0] rd_s3;
	logic             fwd_s3;
	logic [2:0][15:0] fwdd_s3;
	logic [2:0][15:0] acc_mem [GRID_POINTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	// output stage: add and saturate
	logic [2:0][15:0] old_acc;
	logic [2:0][15:0] new_acc;
	logic [2:0][16:0] sum;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pay_s3.first) old_acc[i] = '0;
			else if (fwd_s3) old_acc[i] = fwdd_s3[i];
			else old_acc[i] = rd_s3[i];
			sum[i]     = {1'b0, old_acc[i]} + {1'b0, ct_s3[i]};
			new_acc[i] = sum[i][16] ? 16'hFFFF : sum[i][15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fwd_s3 <= 1'b0;
		else if (adv) fwd_s3 <= v_s3 && v_s2 && (pay_s3.idx == pay_s2.idx);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_s3  <= pay_s2;
			fwdd_s3 <= new_acc;
			for (int i = 0; i < 3; i++) begin
				ct_s3[i] <= (|cprod[i][51:32]) ? 16'hFFFF : cprod[i][31:16];
			end
		end
	end

	// the 8-bit index covers the whole store depth
	always_ff @(posedge clk) begin
		if (adv) rd_s3 <= acc_mem[pay_s2.idx[ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3) acc_mem[pay_s3.idx[ADDR_W-1:0]] <= new_acc;
	end

	logic [2:0][15:0] color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) color_valid <= 1'b0;
		else if (adv) color_valid <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3) color_q <= new_acc;
	end

	assign color_red   = color_q[0];
	assign color_green = color_q[1];
	assign color_blue  = color_q[2];

`ifndef SYNTHESIS
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!color_valid |-> !point_stall)
		else $error("point stalled with empty output register");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(color_valid && color_stall) |=> (v_s3 == $past(v_s3)) && (v_s2 == $past(v_s2)))
		else $error("pipe moved while result held");

	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s3 |-> v_s3)
		else $error("forward flag on an empty stage");
`endif

endmodule

`default_nettype wire
